>>> hw/rtl/pppp_pkg.sv
package pppp_pkg;

   typedef enum logic [2:0] {
      PH_TAG,
      PH_VARINT,
      PH_LENGTH,
      PH_SKIP,
      PH_TEXT,
      PH_STOPPED
   } phase_type;

   localparam logic [2:0] WIRE_VARINT  = 3'd0;
   localparam logic [2:0] WIRE_FIXED64 = 3'd1;
   localparam logic [2:0] WIRE_LENGTH  = 3'd2;
   localparam logic [2:0] WIRE_FIXED32 = 3'd5;

   localparam logic [4:0] FIELD_PORT = 5'd1;
   localparam logic [4:0] FIELD_TEXT = 5'd2;

   localparam logic [7:0] SKIP_FIXED64 = 8'd8;
   localparam logic [7:0] SKIP_FIXED32 = 8'd4;

   localparam logic [5:0] SHIFT_LIMIT = 6'd32;
   localparam logic [5:0] SHIFT_STEP  = 6'd7;

   localparam logic [7:0] TEXT_LIMIT_RESET = 8'd240;

   typedef struct packed {
      logic        text_valid;
      logic [7:0]  text_byte;
      logic        text_plain;
      logic        text_first;
      logic        packet_done;
      logic [31:0] port_number;
      logic        port_found;
      logic        has_payload;
      logic        parse_stopped;
   } result_type;

endpackage

>>> hw/rtl/pppp_parser.sv
module pppp_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          data_byte,
   input  logic [7:0]          bytes_after,
   input  logic [7:0]          text_limit,
   output pppp_pkg::result_type result
);
   import pppp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [4:0]  field_ff, field_in;
   logic [31:0] acc_ff, acc_in;
   logic [5:0]  shift_ff, shift_in;
   logic [7:0]  togo_ff, togo_in;
   logic [31:0] port_ff, port_in;
   logic        found_ff, found_in;
   logic        payload_ff, payload_in;
   logic        plain_ff, plain_in;
   logic        first_ff, first_in;

   logic [38:0] part;
   logic [31:0] acc_next;
   logic [5:0]  shift_next;
   logic        varint_end;
   logic        last_byte;
   logic [2:0]  wire_type;

   assign last_byte  = (bytes_after == 8'd0);
   assign wire_type  = data_byte[2:0];
   assign part       = {32'd0, data_byte[6:0]} << shift_ff;
   assign acc_next   = (shift_ff < SHIFT_LIMIT) ? (acc_ff | part[31:0]) : acc_ff;
   assign shift_next = (shift_ff < SHIFT_LIMIT) ? (shift_ff + SHIFT_STEP) : shift_ff;
   assign varint_end = !data_byte[7] || last_byte;

   always_comb begin
      phase_in   = phase_ff;
      field_in   = field_ff;
      acc_in     = acc_ff;
      shift_in   = shift_ff;
      togo_in    = togo_ff;
      port_in    = port_ff;
      found_in   = found_ff;
      payload_in = payload_ff;
      plain_in   = plain_ff;
      first_in   = first_ff;
      result     = '0;

      unique case (phase_ff)
         PH_TAG: begin
            if (!last_byte) begin
               field_in = data_byte[7:3];
               acc_in   = 32'd0;
               shift_in = 6'd0;
               case (wire_type)
                  WIRE_VARINT: phase_in = PH_VARINT;
                  WIRE_FIXED64: begin
                     togo_in  = SKIP_FIXED64;
                     phase_in = PH_SKIP;
                  end
                  WIRE_FIXED32: begin
                     togo_in  = SKIP_FIXED32;
                     phase_in = PH_SKIP;
                  end
                  WIRE_LENGTH: phase_in = PH_LENGTH;
                  default: phase_in = PH_STOPPED;
               endcase
            end
         end
         PH_VARINT: begin
            acc_in   = acc_next;
            shift_in = shift_next;
            if (varint_end) begin
               if (field_ff == FIELD_PORT) begin
                  port_in  = acc_next;
                  found_in = 1'b1;
               end
               phase_in = PH_TAG;
            end
         end
         PH_LENGTH: begin
            acc_in   = acc_next;
            shift_in = shift_next;
            if (varint_end) begin
               if (acc_next > {24'd0, bytes_after}) begin
                  phase_in = PH_STOPPED;
               end else if (acc_next == 32'd0) begin
                  phase_in = PH_TAG;
               end else if (field_ff == FIELD_TEXT) begin
                  payload_in = 1'b1;
                  plain_in   = (port_ff == 32'd1) && (acc_next < {24'd0, text_limit});
                  first_in   = 1'b1;
                  togo_in    = acc_next[7:0];
                  phase_in   = PH_TEXT;
               end else begin
                  togo_in  = acc_next[7:0];
                  phase_in = PH_SKIP;
               end
            end
         end
         PH_SKIP, PH_TEXT: begin
            if (phase_ff == PH_TEXT) begin
               result.text_valid = 1'b1;
               result.text_byte  = data_byte;
               result.text_plain = plain_ff;
               result.text_first = first_ff;
               first_in          = 1'b0;
            end
            if (togo_ff != 8'd0) begin
               togo_in = togo_ff - 8'd1;
            end
            if (togo_in == 8'd0) begin
               phase_in = PH_TAG;
            end
         end
         default: begin
         end
      endcase

      result.packet_done   = last_byte;
      result.port_number   = port_in;
      result.port_found    = found_in;
      result.has_payload   = payload_in;
      result.parse_stopped = (phase_in == PH_STOPPED);

      if (last_byte) begin
         phase_in   = PH_TAG;
         field_in   = 5'd0;
         acc_in     = 32'd0;
         shift_in   = 6'd0;
         togo_in    = 8'd0;
         port_in    = 32'd0;
         found_in   = 1'b0;
         payload_in = 1'b0;
         plain_in   = 1'b0;
         first_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_TAG;
         field_ff   <= 5'd0;
         acc_ff     <= 32'd0;
         shift_ff   <= 6'd0;
         togo_ff    <= 8'd0;
         port_ff    <= 32'd0;
         found_ff   <= 1'b0;
         payload_ff <= 1'b0;
         plain_ff   <= 1'b0;
         first_ff   <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         field_ff   <= field_in;
         acc_ff     <= acc_in;
         shift_ff   <= shift_in;
         togo_ff    <= togo_in;
         port_ff    <= port_in;
         found_ff   <= found_in;
         payload_ff <= payload_in;
         plain_ff   <= plain_in;
         first_ff   <= first_in;
      end
   end

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      step && last_byte |=> phase_ff == PH_TAG && !found_ff && !payload_ff)
      else $error("parse state not cleared after the last beat of a packet");

   a_count_live: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SKIP || phase_ff == PH_TEXT) |-> togo_ff != 8'd0)
      else $error("skip or text phase with no bytes left to go");

endmodule

>>> hw/rtl/protobuf_port_and_payload_parser.sv
// Throughput: one beat per cycle while the result register can take it; the parse
// state updates in a single pass from the input register into the rsp_ result register.
// Either side may stall; an input register and a result register part them.
// Reset (synchronous, active high) empties both registers, returns parsing
// to the tag phase with all flags cleared, and sets text_limit to 240.
module protobuf_port_and_payload_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic [7:0]  req_bytes_after,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_text_valid,
   output logic [7:0]  rsp_text_byte,
   output logic        rsp_text_plain,
   output logic        rsp_text_first,
   output logic        rsp_packet_done,
   output logic [31:0] rsp_port_number,
   output logic        rsp_port_found,
   output logic        rsp_has_payload,
   output logic        rsp_parse_stopped,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_text_limit
);
   import pppp_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic [7:0] in_after_ff;
   logic       out_valid_ff;
   result_type out_ff, out_in;
   logic [7:0] limit_ff;
   logic       out_free;
   logic       advance;
   logic       req_take;

   assign csr_ready = 1'b1;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   pppp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .data_byte   (in_byte_ff),
      .bytes_after (in_after_ff),
      .text_limit  (limit_ff),
      .result      (out_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= TEXT_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_text_limit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_data_byte;
         in_after_ff <= req_bytes_after;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_text_valid    = out_ff.text_valid;
   assign rsp_text_byte     = out_ff.text_byte;
   assign rsp_text_plain    = out_ff.text_plain;
   assign rsp_text_first    = out_ff.text_first;
   assign rsp_packet_done   = out_ff.packet_done;
   assign rsp_port_number   = out_ff.port_number;
   assign rsp_port_found    = out_ff.port_found;
   assign rsp_has_payload   = out_ff.has_payload;
   assign rsp_parse_stopped = out_ff.parse_stopped;

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("input stalled while the pipeline could move");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("result register empty after a beat moved into it");

   a_first_is_text: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_text_first || rsp_text_plain) |-> rsp_text_valid)
      else $error("text marker set on a beat that carries no text");

endmodule
